>>> src/csmv_pkg.sv
// csmv_pkg: shared widths, constants and float helper functions for the motion vector block
// no dependencies; imported by every module under src
`default_nettype none

package csmv_pkg;

  localparam int MANT_W = 24;
  localparam int REM_W  = 25;
  localparam int QUO_W  = 26;
  localparam int EXP_W  = 11;
  localparam int NRM_W  = 27;

  localparam logic [31:0] HALF_BITS = 32'h3F000000;
  localparam logic [7:0]  EXP_MAX   = 8'hFF;

  function automatic logic is_finite(input logic [31:0] f);
    return f[30:23] != EXP_MAX;
  endfunction

  // leading zeros of a 27-bit word, 27 when empty
  function automatic logic [4:0] lzc27(input logic [NRM_W-1:0] v);
    logic [4:0] n;
    logic       hit;
    n   = 5'd27;
    hit = 1'b0;
    for (int i = NRM_W - 1; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n   = 5'(NRM_W - 1 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  // n holds 24 mantissa bits, guard and sticky; e is the biased exponent of n[25]
  function automatic logic [31:0] round_pack(input logic sgn, input logic signed [EXP_W-1:0] e,
                                             input logic [QUO_W-1:0] n);
    logic [QUO_W-1:0]        ns;
    logic [QUO_W-1:0]        lost;
    logic [4:0]              sh;
    logic signed [EXP_W-1:0] shs;
    logic [7:0]              ef;
    logic                    rnd;
    logic [30:0]             mag;
    ns   = n;
    lost = '0;
    ef   = e[7:0];
    shs  = 11'sd1 - e;
    sh   = '0;
    if (e <= 11'sd0) begin
      sh   = (shs > 11'sd26) ? 5'd26 : shs[4:0];
      lost = n & ~({QUO_W{1'b1}} << sh);
      ns   = (n >> sh) | {{(QUO_W-1){1'b0}}, |lost};
      ef   = 8'd0;
    end
    if (!ns[QUO_W-1]) ef = 8'd0;
    rnd = ns[1] & (ns[0] | ns[2]);
    mag = {ef, ns[24:2]} + {30'd0, rnd};
    if (e >= 11'sd255) mag = {EXP_MAX, 23'd0};
    return {sgn, mag};
  endfunction

  // multiply by one half with a single rounding
  function automatic logic [31:0] half_bits(input logic [31:0] f);
    logic [30:0] mag;
    if (f[30:23] >= 8'd2) mag = {f[30:23] - 8'd1, f[22:0]};
    else mag = {1'b0, f[30:1]} + {30'd0, f[0] & f[1]};
    return {f[31], mag};
  endfunction

endpackage

`default_nettype wire

>>> src/csmv_div_cell.sv
// csmv_div_cell: one restoring division step, one quotient bit per cell, registered
// depends on csmv_pkg
`default_nettype none

module csmv_div_cell
  import csmv_pkg::*;
#(
  parameter int SW = 13
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [REM_W-1:0]  rem,
  input  logic [MANT_W-1:0] dvs,
  input  logic [QUO_W-1:0]  quo,
  input  logic [SW-1:0]     side,
  output logic [REM_W-1:0]  fwd_rem,
  output logic [MANT_W-1:0] fwd_dvs,
  output logic [QUO_W-1:0]  fwd_quo,
  output logic [SW-1:0]     fwd_side
);

  logic             take;
  logic [REM_W-1:0] diff;

  always_comb begin
    take = rem >= {1'b0, dvs};
    diff = take ? rem - {1'b0, dvs} : rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_side <= '0;
    end else if (en) begin
      fwd_side <= side;
    end
    if (en) begin
      fwd_rem <= {diff[REM_W-2:0], 1'b0};
      fwd_dvs <= dvs;
      fwd_quo <= {quo[QUO_W-2:0], take};
    end
  end

endmodule

`default_nettype wire

>>> src/csmv_div.sv
// csmv_div: pipelined single precision divide, operand prep, a chain of division cells, rounding
// depends on csmv_pkg and csmv_div_cell
`default_nettype none

module csmv_div
  import csmv_pkg::*;
#(
  parameter int TW = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [31:0]   num,
  input  logic [31:0]   den,
  input  logic [TW-1:0] tag,
  output logic [31:0]   quot,
  output logic [TW-1:0] quot_tag
);

  localparam int SW = 1 + EXP_W + TW;

  logic [MANT_W-1:0]       num_man;
  logic [MANT_W-1:0]       den_man;
  logic [4:0]              lz_n;
  logic [4:0]              lz_d;
  logic signed [EXP_W-1:0] exp_n;
  logic signed [EXP_W-1:0] exp_d;

  logic [REM_W-1:0]  p_rem;
  logic [MANT_W-1:0] p_dvs;
  logic [SW-1:0]     p_side;

  logic [REM_W-1:0]  c_rem  [QUO_W+1];
  logic [MANT_W-1:0] c_dvs  [QUO_W+1];
  logic [QUO_W-1:0]  c_quo  [QUO_W+1];
  logic [SW-1:0]     c_side [QUO_W+1];

  always_comb begin
    num_man = {num[30:23] != 8'd0, num[22:0]};
    den_man = {den[30:23] != 8'd0, den[22:0]};
    lz_n    = lzc27({num_man, 3'b111});
    lz_d    = lzc27({den_man, 3'b111});
    exp_n   = $signed({3'b000, (num[30:23] == 8'd0) ? 8'd1 : num[30:23]});
    exp_d   = $signed({3'b000, (den[30:23] == 8'd0) ? 8'd1 : den[30:23]});
  end

  // operand prep: normalise subnormals
  always_ff @(posedge clk) begin
    if (rst) begin
      p_side <= '0;
    end else if (en) begin
      p_side <= {num[31] ^ den[31],
                 exp_n - $signed({6'd0, lz_n}) - exp_d + $signed({6'd0, lz_d}), tag};
    end
    if (en) begin
      p_rem <= {1'b0, num_man << lz_n};
      p_dvs <= den_man << lz_d;
    end
  end

  assign c_rem[0]  = p_rem;
  assign c_dvs[0]  = p_dvs;
  assign c_side[0] = p_side;
  assign c_quo[0]  = '0;

  for (genvar k = 0; k < QUO_W; k++) begin : g_cell
    csmv_div_cell #(.SW(SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .rem      (c_rem[k]),
      .dvs      (c_dvs[k]),
      .quo      (c_quo[k]),
      .side     (c_side[k]),
      .fwd_rem  (c_rem[k+1]),
      .fwd_dvs  (c_dvs[k+1]),
      .fwd_quo  (c_quo[k+1]),
      .fwd_side (c_side[k+1])
    );
  end

  logic [QUO_W-1:0]        q;
  logic                    st;
  logic signed [EXP_W-1:0] e_q;
  logic signed [EXP_W-1:0] e_r;
  logic [QUO_W-1:0]        n_r;

  always_comb begin
    q   = c_quo[QUO_W];
    st  = |c_rem[QUO_W];
    e_q = $signed(c_side[QUO_W][SW-2:TW]);
    if (q[QUO_W-1]) begin
      n_r = {q[25:2], q[1], q[0] | st};
      e_r = e_q + 11'sd127;
    end else begin
      n_r = {q[24:1], q[0], st};
      e_r = e_q + 11'sd126;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quot_tag <= '0;
    end else if (en) begin
      quot_tag <= c_side[QUO_W][TW-1:0];
    end
    if (en) begin
      quot <= round_pack(c_side[QUO_W][SW-1], e_r, n_r);
    end
  end

endmodule

`default_nettype wire

>>> src/csmv_fadd.sv
// csmv_fadd: four stage single precision adder for finite operands, round to nearest even
// depends on csmv_pkg
`default_nettype none

module csmv_fadd
  import csmv_pkg::*;
#(
  parameter int TW = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [31:0]   a,
  input  logic [31:0]   b,
  input  logic [TW-1:0] tag,
  output logic [31:0]   sum,
  output logic [TW-1:0] sum_tag
);

  // swap and exponent difference
  logic        a_big;
  logic [31:0] big;
  logic [31:0] sml;
  logic [7:0]  be;
  logic [7:0]  se;

  always_comb begin
    a_big = a[30:0] >= b[30:0];
    big   = a_big ? a : b;
    sml   = a_big ? b : a;
    be    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    se    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
  end

  logic              s1_sign;
  logic              s1_sub;
  logic [7:0]        s1_exp;
  logic [7:0]        s1_diff;
  logic [MANT_W-1:0] s1_mb;
  logic [MANT_W-1:0] s1_ms;
  logic              s1_zero2;
  logic              s1_zsign;
  logic [TW-1:0]     s1_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag <= '0;
    end else if (en) begin
      s1_tag <= tag;
    end
    if (en) begin
      s1_sign  <= big[31];
      s1_sub   <= a[31] ^ b[31];
      s1_exp   <= be;
      s1_diff  <= be - se;
      s1_mb    <= {big[30:23] != 8'd0, big[22:0]};
      s1_ms    <= {sml[30:23] != 8'd0, sml[22:0]};
      s1_zero2 <= (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
      s1_zsign <= a[31] & b[31];
    end
  end

  // align and add
  logic [NRM_W-1:0] al_a;
  logic [NRM_W-1:0] al_b0;
  logic [NRM_W-1:0] al_b;
  logic [NRM_W:0]   raw;

  always_comb begin
    al_a  = {s1_mb, 3'b000};
    al_b0 = {s1_ms, 3'b000};
    if (s1_diff >= 8'd27) begin
      al_b = {{(NRM_W-1){1'b0}}, |s1_ms};
    end else begin
      al_b = (al_b0 >> s1_diff[4:0]) |
             {{(NRM_W-1){1'b0}}, |(al_b0 & ~({NRM_W{1'b1}} << s1_diff[4:0]))};
    end
    raw = s1_sub ? {1'b0, al_a} - {1'b0, al_b} : {1'b0, al_a} + {1'b0, al_b};
  end

  logic [NRM_W:0] s2_sum;
  logic [7:0]     s2_exp;
  logic           s2_sign;
  logic           s2_zero2;
  logic           s2_zsign;
  logic [TW-1:0]  s2_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_tag <= '0;
    end else if (en) begin
      s2_tag <= s1_tag;
    end
    if (en) begin
      s2_sum   <= raw;
      s2_exp   <= s1_exp;
      s2_sign  <= s1_sign;
      s2_zero2 <= s1_zero2;
      s2_zsign <= s1_zsign;
    end
  end

  // normalise
  logic [4:0]       lz;
  logic [7:0]       lim;
  logic [4:0]       sh;
  logic [NRM_W-1:0] nrm;
  logic [8:0]       e_n;

  always_comb begin
    lz  = lzc27(s2_sum[NRM_W-1:0]);
    lim = s2_exp - 8'd1;
    sh  = lz;
    if (s2_sum[NRM_W]) begin
      nrm = {s2_sum[NRM_W:2], s2_sum[1] | s2_sum[0]};
      e_n = {1'b0, s2_exp} + 9'd1;
    end else begin
      if ({3'b000, lz} > lim) sh = lim[4:0];
      nrm = s2_sum[NRM_W-1:0] << sh;
      e_n = {1'b0, s2_exp} - {4'd0, sh};
    end
  end

  logic [NRM_W-1:0] s3_nrm;
  logic [8:0]       s3_exp;
  logic             s3_sign;
  logic             s3_zero;
  logic             s3_zero2;
  logic             s3_zsign;
  logic [TW-1:0]    s3_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_tag <= '0;
    end else if (en) begin
      s3_tag <= s2_tag;
    end
    if (en) begin
      s3_nrm   <= nrm;
      s3_exp   <= e_n;
      s3_sign  <= s2_sign;
      s3_zero  <= s2_sum == '0;
      s3_zero2 <= s2_zero2;
      s3_zsign <= s2_zsign;
    end
  end

  // round and pack
  logic [31:0] res;

  always_comb begin
    if (s3_zero) begin
      res = {s3_zero2 & s3_zsign, 31'd0};
    end else begin
      res = round_pack(s3_sign, $signed({2'b00, s3_exp}),
                       {s3_nrm[26:3], s3_nrm[2], |s3_nrm[1:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_tag <= '0;
    end else if (en) begin
      sum_tag <= s3_tag;
    end
    if (en) begin
      sum <= res;
    end
  end

endmodule

`default_nettype wire

>>> src/clip_space_motion_vector_top.sv
// clip_space_motion_vector_top: stages input, divide, uv add, motion subtract, output
// one item per cycle unless held; divide is a 26 cell chain, one quotient bit per cell
// uv adders and motion subtract are four stage pipelines; the whole pipe advances together
// and holds only when a result waits at the output and another has reached the last stage
// reset clears valid bits, tags and side fields; other payload registers are not reset
// depends on csmv_pkg, csmv_div, csmv_fadd
`default_nettype none

module clip_space_motion_vector_top
  import csmv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        pos_valid,
  output logic        pos_stall,
  input  logic [31:0] cur_x,
  input  logic [31:0] cur_y,
  input  logic [31:0] cur_z,
  input  logic [31:0] cur_w,
  input  logic [31:0] prev_x,
  input  logic [31:0] prev_y,
  input  logic [31:0] prev_z,
  input  logic [31:0] prev_w,
  output logic        mv_valid,
  input  logic        mv_stall,
  output logic [31:0] motion_x,
  output logic [31:0] motion_y,
  output logic        valid_res
);

  logic en;
  logic last_valid;

  assign en        = !(last_valid && mv_valid && mv_stall);
  assign pos_stall = !en;

  // input stage
  logic        v0;
  logic        bad0;
  logic [31:0] r_cx;
  logic [31:0] r_cy;
  logic [31:0] r_cw;
  logic [31:0] r_px;
  logic [31:0] r_py;
  logic [31:0] r_pw;
  logic        bad_in;

  always_comb begin
    bad_in = !is_finite(cur_x) || !is_finite(cur_y) || !is_finite(cur_z) ||
             !is_finite(cur_w) || !is_finite(prev_x) || !is_finite(prev_y) ||
             !is_finite(prev_z) || !is_finite(prev_w) ||
             cur_w[31] || (cur_w[30:0] == 31'd0) ||
             prev_w[31] || (prev_w[30:0] == 31'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= pos_valid;
    end
    if (en) begin
      bad0 <= bad_in;
      r_cx <= cur_x;
      r_cy <= cur_y;
      r_cw <= cur_w;
      r_px <= prev_x;
      r_py <= prev_y;
      r_pw <= prev_w;
    end
  end

  // coord / w
  logic [31:0] q_cx, q_px, q_cy, q_py;
  logic [1:0]  t_cx, t_px, t_cy, t_py;

  csmv_div #(.TW(2)) u_div_cx (
    .clk(clk), .rst(rst), .en(en), .num(r_cx), .den(r_cw), .tag({v0, bad0}),
    .quot(q_cx), .quot_tag(t_cx)
  );
  csmv_div #(.TW(2)) u_div_px (
    .clk(clk), .rst(rst), .en(en), .num(r_px), .den(r_pw), .tag({v0, bad0}),
    .quot(q_px), .quot_tag(t_px)
  );
  csmv_div #(.TW(2)) u_div_cy (
    .clk(clk), .rst(rst), .en(en), .num(r_cy), .den(r_cw), .tag({v0, bad0}),
    .quot(q_cy), .quot_tag(t_cy)
  );
  csmv_div #(.TW(2)) u_div_py (
    .clk(clk), .rst(rst), .en(en), .num(r_py), .den(r_pw), .tag({v0, bad0}),
    .quot(q_py), .quot_tag(t_py)
  );

  // uv = q * 0.5 + 0.5
  logic [31:0] u_cx, u_px, u_cy, u_py;
  logic [1:0]  tu_cx, tu_px, tu_cy, tu_py;

  csmv_fadd #(.TW(2)) u_uv_cx (
    .clk(clk), .rst(rst), .en(en), .a(half_bits(q_cx)), .b(HALF_BITS),
    .tag({t_cx[1], t_cx[0] | !is_finite(q_cx)}), .sum(u_cx), .sum_tag(tu_cx)
  );
  csmv_fadd #(.TW(2)) u_uv_px (
    .clk(clk), .rst(rst), .en(en), .a(half_bits(q_px)), .b(HALF_BITS),
    .tag({t_px[1], t_px[0] | !is_finite(q_px)}), .sum(u_px), .sum_tag(tu_px)
  );
  csmv_fadd #(.TW(2)) u_uv_cy (
    .clk(clk), .rst(rst), .en(en), .a(half_bits(q_cy)), .b(HALF_BITS),
    .tag({t_cy[1], t_cy[0] | !is_finite(q_cy)}), .sum(u_cy), .sum_tag(tu_cy)
  );
  csmv_fadd #(.TW(2)) u_uv_py (
    .clk(clk), .rst(rst), .en(en), .a(half_bits(q_py)), .b(HALF_BITS),
    .tag({t_py[1], t_py[0] | !is_finite(q_py)}), .sum(u_py), .sum_tag(tu_py)
  );

  // motion = current uv - previous uv
  logic [31:0] d_x, d_y;
  logic [1:0]  td_x, td_y;

  csmv_fadd #(.TW(2)) u_mv_x (
    .clk(clk), .rst(rst), .en(en), .a(u_cx), .b({~u_px[31], u_px[30:0]}),
    .tag({tu_cx[1] & tu_px[1], tu_cx[0] | tu_px[0]}), .sum(d_x), .sum_tag(td_x)
  );
  csmv_fadd #(.TW(2)) u_mv_y (
    .clk(clk), .rst(rst), .en(en), .a(u_cy), .b({~u_py[31], u_py[30:0]}),
    .tag({tu_cy[1] & tu_py[1], tu_cy[0] | tu_py[0]}), .sum(d_y), .sum_tag(td_y)
  );

  logic ok;

  always_comb begin
    last_valid = td_x[1] & td_y[1];
    ok         = !(td_x[0] | td_y[0]) && is_finite(d_x) && is_finite(d_y);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      mv_valid <= 1'b0;
    end else if (en && last_valid) begin
      mv_valid <= 1'b1;
    end else if (!mv_stall) begin
      mv_valid <= 1'b0;
    end
    if (en && last_valid) begin
      motion_x  <= ok ? d_x : 32'd0;
      motion_y  <= ok ? d_y : 32'd0;
      valid_res <= ok;
    end
  end

  a_zero_when_rejected: assert property (@(posedge clk) disable iff (rst)
    mv_valid && !valid_res |-> motion_x == 32'd0 && motion_y == 32'd0)
    else $error("rejected item carries non-zero motion");

  a_finite_when_ok: assert property (@(posedge clk) disable iff (rst)
    mv_valid && valid_res |-> motion_x[30:23] != EXP_MAX && motion_y[30:23] != EXP_MAX)
    else $error("accepted motion is not finite");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    pos_stall |-> mv_valid && mv_stall)
    else $error("input stalled without a waiting result");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !mv_valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// tb_top: self-checking testbench for clip_space_motion_vector_top
// predicts each motion vector from double precision arithmetic rounded to single per operation
// depends only on the rtl under src
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [31:0] mx;
    logic [31:0] my;
    logic        ok;
  } motion_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        pos_valid = 1'b0;
  logic        pos_stall;
  logic [31:0] cur_x = '0, cur_y = '0, cur_z = '0, cur_w = '0;
  logic [31:0] prev_x = '0, prev_y = '0, prev_z = '0, prev_w = '0;
  logic        mv_valid;
  logic        mv_stall = 1'b0;
  logic [31:0] motion_x, motion_y;
  logic        valid_res;

  motion_t motion_q[$];
  int      errors = 0;
  int      sent = 0;
  int      got = 0;
  int      rejected = 0;
  int      cycles = 0;
  int      send_idle = 0;
  int      recv_idle = 0;
  int      hold_cycles = 0;

  clip_space_motion_vector_top uut (
    .clk(clk), .rst(rst),
    .pos_valid(pos_valid), .pos_stall(pos_stall),
    .cur_x(cur_x), .cur_y(cur_y), .cur_z(cur_z), .cur_w(cur_w),
    .prev_x(prev_x), .prev_y(prev_y), .prev_z(prev_z), .prev_w(prev_w),
    .mv_valid(mv_valid), .mv_stall(mv_stall),
    .motion_x(motion_x), .motion_y(motion_y), .valid_res(valid_res)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t with %0d results outstanding", $time, motion_q.size());
      $display("clip_space_motion_vector_top regression: fail");
      $finish;
    end
  end

  // single bit pattern to real, exact; infinities and nans carried over
  function automatic real sp_to_real(input logic [31:0] f);
    logic [63:0] d;
    logic [23:0] mm;
    int          k;
    k = 0;
    mm = {1'b0, f[22:0]};
    if (f[30:23] == 8'hFF) begin
      d = {f[31], 11'h7FF, f[22:0], 29'd0};
    end else if (f[30:23] == 8'd0) begin
      if (f[22:0] == 23'd0) begin
        d = {f[31], 63'd0};
      end else begin
        while (!mm[23]) begin
          mm = mm << 1;
          k++;
        end
        d = {f[31], 11'(1023 - 126 - k), mm[22:0], 29'd0};
      end
    end else begin
      d = {f[31], 11'(int'(f[30:23]) - 127 + 1023), f[22:0], 29'd0};
    end
    return $bitstoreal(d);
  endfunction

  // real to single with round to nearest even, subnormals kept
  function automatic logic [31:0] real_to_sp(input real r);
    logic [63:0] d;
    logic [63:0] sig;
    logic [63:0] mant;
    logic        g;
    logic        st;
    int          be;
    int          sh;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF) return {d[63], 8'hFF, 23'h400000};
    if (d[62:52] == 11'd0) return {d[63], 31'd0};
    be = int'(d[62:52]) - 1023 + 127;
    sig = {11'd0, 1'b1, d[51:0]};
    sh = (be >= 1) ? 29 : 30 - be;
    if (sh > 60) sh = 60;
    mant = sig >> sh;
    g = sig[sh-1];
    st = |(sig & ((64'd1 << (sh - 1)) - 64'd1));
    mant = mant + {63'd0, g & (st | mant[0])};
    if (be >= 1) begin
      if (mant[24]) begin
        mant = mant >> 1;
        be++;
      end
      if (be >= 255) return {d[63], 8'hFF, 23'd0};
      return {d[63], 8'(be), mant[22:0]};
    end
    return {d[63], mant[30:0]};
  endfunction

  function automatic logic [31:0] clip_to_uv(input logic [31:0] c, input logic [31:0] w);
    logic [31:0] q;
    logic [31:0] h;
    q = real_to_sp(sp_to_real(c) / sp_to_real(w));
    h = real_to_sp(sp_to_real(q) * 0.5);
    return real_to_sp(sp_to_real(h) + 0.5);
  endfunction

  function automatic logic fin(input logic [31:0] f);
    return f[30:23] != 8'hFF;
  endfunction

  function automatic motion_t predict_motion(input logic [31:0] cx, cy, cz, cw,
                                             input logic [31:0] px, py, pz, pw);
    motion_t m;
    m = '0;
    m.ok = fin(cx) & fin(cy) & fin(cz) & fin(cw) & fin(px) & fin(py) & fin(pz) & fin(pw);
    if (m.ok && (cw[31] || cw[30:0] == 31'd0 || pw[31] || pw[30:0] == 31'd0)) m.ok = 1'b0;
    if (m.ok) begin
      m.mx = real_to_sp(sp_to_real(clip_to_uv(cx, cw)) - sp_to_real(clip_to_uv(px, pw)));
      m.my = real_to_sp(sp_to_real(clip_to_uv(cy, cw)) - sp_to_real(clip_to_uv(py, pw)));
      if (!fin(m.mx) || !fin(m.my)) m.ok = 1'b0;
    end
    if (!m.ok) begin
      m.mx = '0;
      m.my = '0;
    end
    return m;
  endfunction

  task automatic send_pos(input logic [31:0] cx, cy, cz, cw, px, py, pz, pw);
    cur_x <= cx;
    cur_y <= cy;
    cur_z <= cz;
    cur_w <= cw;
    prev_x <= px;
    prev_y <= py;
    prev_z <= pz;
    prev_w <= pw;
    pos_valid <= 1'b1;
    @(posedge clk);
    while (pos_stall) @(posedge clk);
    motion_q.push_back(predict_motion(cx, cy, cz, cw, px, py, pz, pw));
    sent++;
    if ($urandom_range(99) < send_idle) begin
      pos_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    motion_t e;
    if (!rst && mv_valid && !mv_stall) begin
      got++;
      if (motion_q.size() == 0) begin
        $display("%0t: unexpected result mx=%h my=%h ok=%b", $time, motion_x, motion_y,
                 valid_res);
        errors++;
      end else begin
        e = motion_q.pop_front();
        if (!valid_res) rejected++;
        if (motion_x !== e.mx) begin
          $display("%0t: motion_x expected %h actual %h", $time, e.mx, motion_x);
          errors++;
        end
        if (motion_y !== e.my) begin
          $display("%0t: motion_y expected %h actual %h", $time, e.my, motion_y);
          errors++;
        end
        if (valid_res !== e.ok) begin
          $display("%0t: valid_res expected %b actual %b", $time, e.ok, valid_res);
          errors++;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      mv_stall <= 1'b1;
    end else begin
      mv_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // mostly finite values over a wide spread of exponents, rarely specials
  function automatic logic [31:0] rand_float(input logic positive);
    logic [31:0] f;
    int          r;
    f = $urandom;
    r = $urandom_range(99);
    if (r < 50) f[30:23] = 8'($urandom_range(150, 104));
    else if (r < 60) f[30:23] = 8'd0;
    else if (r < 64) f[30:23] = 8'd254;
    else if (r < 66) f[30:23] = 8'hFF;
    else if (r < 70) f[30:0] = 31'd0;
    else if (f[30:23] == 8'hFF) f[30:23] = 8'd200;
    if (positive && $urandom_range(99) < 95) f[31] = 1'b0;
    return f;
  endfunction

  task automatic send_random(input int n);
    logic [31:0] v[8];
    repeat (n) begin
      if ($urandom_range(99) < 8) begin
        foreach (v[i]) v[i] = $urandom;
      end else begin
        foreach (v[i]) v[i] = rand_float(i == 3 || i == 7);
        if ($urandom_range(99) < 10) begin
          v[4] = v[0];
          v[5] = v[1];
          v[7] = v[3];
        end
      end
      send_pos(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
    end
  endtask

  task automatic test_directed();
    send_pos(32'h3F800000, 32'h3F000000, 32'h0, 32'h3F800000,
             32'h3E800000, 32'hBF000000, 32'h0, 32'h40000000);
    send_pos('0, '0, '0, '0, '0, '0, '0, '0);
    send_pos(32'h3F800000, 32'h3F800000, 0, 32'h80000000, 0, 0, 0, 32'h3F800000);
    send_pos(32'h3F800000, 32'h3F800000, 0, 32'h3F800000, 0, 0, 0, 32'hBF800000);
    send_pos(32'h3F800000, 32'h3F800000, 32'h7FC00000, 32'h3F800000, 0, 0, 0, 32'h3F800000);
    send_pos(32'h7F800000, 0, 0, 32'h3F800000, 0, 0, 0, 32'h3F800000);
    send_pos(0, 0, 0, 32'h3F800000, 0, 32'hFF800000, 0, 32'h3F800000);
    send_pos(0, 0, 0, 32'h3F800000, 0, 0, 32'hFFFFFFFF, 32'h3F800000);
    send_pos(32'h7F7FFFFF, 0, 0, 32'h00000001, 0, 0, 0, 32'h3F800000);
    send_pos(32'h7F7FFFFF, 32'hFF7FFFFF, 32'h7F7FFFFF, 32'h7F7FFFFF,
             32'hFF7FFFFF, 32'h7F7FFFFF, 32'hFF7FFFFF, 32'h7F7FFFFF);
    send_pos(32'h00000001, 32'h807FFFFF, 0, 32'h7F7FFFFF,
             32'h00400000, 32'h80000001, 0, 32'h00000001);
    send_pos(32'h40490FDB, 32'hC0490FDB, 32'h3F800000, 32'h40400000,
             32'h40490FDB, 32'hC0490FDB, 32'h3F800000, 32'h40400000);
    send_pos(32'hBF800000, 32'h3F800000, 0, 32'h3F800000,
             32'h3F800000, 32'hBF800000, 0, 32'h3F800000);
    send_pos(32'h33800000, 32'hB3800000, 0, 32'h3F800000,
             32'h33000001, 32'h0, 0, 32'h3F800000);
    send_pos(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
             32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_pos(32'h7F000000, 32'h7F000000, 0, 32'h3F000000, 0, 0, 0, 32'h3F800000);
    send_pos(32'h12345678, 32'h9ABCDEF0, 32'h55555555, 32'h2AAAAAAA,
             32'h00ABCDEF, 32'h80FEDCBA, 32'h2AAAAAAA, 32'h01000000);
    send_pos(32'h3F800000, 32'h3F800000, 0, 32'h3F800000, 0, 0, 32'h7F800000, 32'h3F800000);
  endtask

  task automatic test_idle_phases();
    send_idle = 0;   recv_idle = 0;   send_random(120);
    send_idle = 75;  recv_idle = 0;   send_random(90);
    send_idle = 0;   recv_idle = 75;  send_random(90);
    send_idle = 7;   recv_idle = 7;   send_random(100);
  endtask

  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    hold_cycles = 300;
    send_random(80);
  endtask

  task automatic test_pause_until_empty();
    send_idle = 30;
    recv_idle = 30;
    send_random(20);
    pos_valid <= 1'b0;
    while (motion_q.size() != 0) @(posedge clk);
    send_random(50);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_idle_phases();
    test_backpressure();
    test_pause_until_empty();
    pos_valid <= 1'b0;
    while (motion_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d position pairs, %0d motion vectors checked, %0d rejected",
             sent, got, rejected);
    $display("directed specials, random floats, idle and stall phases, long output hold");
    if (errors == 0 && motion_q.size() == 0) begin
      $display("clip_space_motion_vector_top regression: pass");
    end else begin
      $display("clip_space_motion_vector_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
src/csmv_pkg.sv
src/csmv_div_cell.sv
src/csmv_div.sv
src/csmv_fadd.sv
src/clip_space_motion_vector_top.sv
dv/tb_top.sv
